// ----- rtl/core/projected_box_corner_tracker_macros.svh -----
// ----------------------------------------------------------------------------
// Projected box corner tracker - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef PROJECTED_BOX_CORNER_TRACKER_MACROS_SVH
`define PROJECTED_BOX_CORNER_TRACKER_MACROS_SVH

// same-cycle implication, off during reset
`define PBCT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbct assertion failed");

// next-cycle implication, off during reset
`define PBCT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbct assertion failed");

// next-cycle implication, checked at every edge
`define PBCT_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pbct assertion failed");

`endif

// ----- rtl/core/pbct_pkg.sv -----
// ----------------------------------------------------------------------------
// pbct_pkg
// Types, constants and helpers of the projected box corner tracker.
// ----------------------------------------------------------------------------
package pbct_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int PIXEL_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_MAT    = 6;
  localparam int BOX_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 3'd7;

  // projection terms: 3 rows of 4
  localparam logic [3:0] NUM_TERMS = 4'd12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_DIV_U,
    S_DIV_V,
    S_UPDATE,
    S_EMIT_LO,
    S_EMIT_HI
  } state_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               cloud_end;
  } point_t;

  typedef struct packed {
    logic               corner_kind;
    logic               corner_found;
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic signed [31:0] corner_z;
    logic signed [15:0] corner_col;
    logic signed [15:0] corner_row;
    logic               run_last;
  } corner_t;

  // signed 64-bit add, saturating
  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

endpackage

// ----- rtl/core/pbct_stream_if.sv -----
// ----------------------------------------------------------------------------
// pbct_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface pbct_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/pbct_div.sv -----
// ----------------------------------------------------------------------------
// pbct_div
// Restoring divider, one quotient bit per cycle, saturated pixel quotient.
// ----------------------------------------------------------------------------
module pbct_div #(
  parameter int PB = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [63:0]   dividend,
  input  logic        [63:0]   divisor,
  output logic                 done,
  output logic signed [PB-1:0] quot
);

  localparam int CNT_W = $clog2(PB + 1);
  localparam logic [PB:0] MAG_MAX = (PB + 1)'((2 ** (PB - 1)) - 1);
  localparam logic [PB:0] MAG_MIN = (PB + 1)'(2 ** (PB - 1));

  logic [63:0]    rem;
  logic [63+PB:0] den;
  logic [PB:0]    q;
  logic [CNT_W-1:0] cnt;
  logic           neg;
  logic           busy;
  logic [63+PB:0] rem_ext;
  logic [63+PB:0] rem_sub;
  logic           ge;
  logic [PB:0]    neg_q;

  assign rem_ext = {{PB{1'b0}}, rem};
  assign ge      = rem_ext >= den;
  assign rem_sub = rem_ext - den;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PB);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitude division, divisor walks down from 2^PB
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[63] ? 64'(-dividend) : dividend;
      den <= {divisor, {PB{1'b0}}};
      q   <= '0;
      neg <= dividend[63];
    end else if (busy) begin
      if (ge) rem <= rem_sub[63:0];
      q   <= {q[PB-1:0], ge};
      den <= den >> 1;
    end
  end

  // truncate toward zero, then clamp to the pixel range
  assign neg_q = ~q + 1'b1;
  always_comb begin
    if (neg) begin
      quot = (q > MAG_MIN) ? {1'b1, {(PB - 1){1'b0}}} : neg_q[PB-1:0];
    end else begin
      quot = (q > MAG_MAX) ? {1'b0, {(PB - 1){1'b1}}} : q[PB-1:0];
    end
  end

endmodule

// ----- rtl/core/projected_box_corner_tracker.sv -----
// ----------------------------------------------------------------------------
// projected_box_corner_tracker
// Projects cloud points through a 3x4 matrix, gates them by a pixel box and
// tracks the low and high corner points; emits both at the end of a cloud.
// ----------------------------------------------------------------------------
//  channel   dir  payload                              transfer
//  points    in   point_x/y/z, cloud_end                valid & ready
//  corners   out  kind, found, x/y/z, col, row, last    valid & ready
//  cfg       in   cfg_index, cfg_data                   cfg_wen
//
//  From one point transfer to the next: the idle state, the 12 terms on the shared
//  32x32 multiplier/accumulator, a check, u/w and v/w in turn on one divider, an update.
//  Points with w <= 0 skip division and the update. A point is taken only when idle.
//  Synchronous reset clears sequencer, trackers and configuration registers; no sweep.
//  On cloud_end two corners follow back to back; no point until both transferred.
// ----------------------------------------------------------------------------
module projected_box_corner_tracker
  import pbct_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pbct_stream_if.sink           points,
  pbct_stream_if.source         corners
);

  localparam int PB = PIXEL_BITS;
  localparam int CW = (PB > BOX_W) ? PB : BOX_W;
  localparam logic signed [PB-1:0] PIX_MAX = {1'b0, {(PB - 1){1'b1}}};
  localparam logic signed [PB-1:0] PIX_MIN = {1'b1, {(PB - 1){1'b0}}};
  localparam logic signed [CW-1:0] OUT_MAX = CW'(32767);
  localparam logic signed [CW-1:0] OUT_MIN = -CW'(32768);
  localparam logic signed [31:0]   ONE     = 32'(1 << FRAC_BITS);

  // configuration registers
  logic [63:0] mat [NUM_MAT];
  logic [31:0] box_x;
  logic [31:0] box_y;

  // sequencer and datapath registers
  state_t             state, state_next;
  logic [3:0]         k;
  logic [3:0]         k_sel;
  logic               prod_v;
  logic [3:0]         prod_idx;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] acc_sum;
  logic signed [63:0] u_r, v_r, w_r;
  logic signed [31:0] pt [3];
  logic               end_r;
  logic signed [PB-1:0] col_r, row_r;

  // trackers
  logic signed [PB-1:0] low_col, low_row, high_col, high_row;
  logic signed [31:0]   low_point [3];
  logic signed [31:0]   high_point [3];
  logic                 low_seen, high_seen;

  logic               in_xfer, out_xfer;
  logic               div_start, div_done;
  logic signed [63:0] div_a;
  logic signed [PB-1:0] div_q;
  logic [63:0]        mrow;
  logic signed [31:0] coef, opnd;
  logic               in_box, lo_hit, hi_hit;
  logic signed [CW-1:0] col_x, row_x;

  assign in_xfer  = points.valid && points.ready;
  assign out_xfer = corners.valid && corners.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MAT; i++) mat[i] <= '0;
      box_x <= '0;
      box_y <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_BOX_X: box_x <= cfg_data[31:0];
        REG_BOX_Y: box_y <= cfg_data[31:0];
        default:   mat[cfg_index] <= cfg_data;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_xfer) state_next = S_MUL;
      S_MUL:     if (k == NUM_TERMS) state_next = S_CHECK;
      S_CHECK: begin
        if (w_r > 0)    state_next = S_DIV_U;
        else if (end_r) state_next = S_EMIT_LO;
        else            state_next = S_IDLE;
      end
      S_DIV_U:   if (div_done) state_next = S_DIV_V;
      S_DIV_V:   if (div_done) state_next = S_UPDATE;
      S_UPDATE:  state_next = end_r ? S_EMIT_LO : S_IDLE;
      S_EMIT_LO: if (out_xfer) state_next = S_EMIT_HI;
      S_EMIT_HI: if (out_xfer) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    points.ready  = (state == S_IDLE);
    corners.valid = (state == S_EMIT_LO) || (state == S_EMIT_HI);
    div_start     = ((state == S_CHECK) && (w_r > 0)) || ((state == S_DIV_U) && div_done);
    div_a         = (state == S_CHECK) ? u_r : v_r;
  end

  // shared multiplier operands: coefficient k times x, y, z or 1.0
  assign k_sel = (k < NUM_TERMS) ? k : '0;
  assign mrow  = mat[k_sel[3:1]];
  assign coef  = k_sel[0] ? mrow[63:32] : mrow[31:0];
  always_comb begin
    case (k_sel[1:0])
      2'd0:    opnd = pt[0];
      2'd1:    opnd = pt[1];
      2'd2:    opnd = pt[2];
      default: opnd = ONE;
    endcase
  end

  assign acc_sum = (prod_idx[1:0] == 2'd0) ? prod : sat_add64(acc, prod);

  // point capture, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      k      <= '0;
      prod_v <= 1'b0;
    end else if (in_xfer) begin
      k      <= '0;
      prod_v <= 1'b0;
    end else if (state == S_MUL) begin
      k      <= k + 1'b1;
      prod_v <= (k < NUM_TERMS);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pt[0] <= points.data.point_x;
      pt[1] <= points.data.point_y;
      pt[2] <= points.data.point_z;
      end_r <= points.data.cloud_end;
    end
    if (state == S_MUL) begin
      prod     <= coef * opnd;
      prod_idx <= k;
      if (prod_v) begin
        acc <= acc_sum;
        if (prod_idx[1:0] == 2'd3) begin
          case (prod_idx[3:2])
            2'd0:    u_r <= acc_sum;
            2'd1:    v_r <= acc_sum;
            default: w_r <= acc_sum;
          endcase
        end
      end
    end
    if ((state == S_DIV_U) && div_done) col_r <= div_q;
    if ((state == S_DIV_V) && div_done) row_r <= div_q;
  end

  pbct_div #(.PB(PB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (w_r),
    .done     (div_done),
    .quot     (div_q)
  );

  // strict box test, then low corner first, high corner otherwise
  assign col_x  = CW'(col_r);
  assign row_x  = CW'(row_r);
  assign in_box = (CW'($signed(box_x[15:0])) < col_x) && (col_x < CW'($signed(box_x[31:16])))
               && (CW'($signed(box_y[15:0])) < row_x) && (row_x < CW'($signed(box_y[31:16])));
  assign lo_hit = in_box && (col_r < low_col) && (row_r < low_row);
  assign hi_hit = in_box && !lo_hit && (col_r > high_col) && (row_r > high_row);

  // tracker update and per-cloud clear
  always_ff @(posedge clk) begin
    if (rst || ((state == S_EMIT_HI) && out_xfer)) begin
      low_col   <= PIX_MAX;
      low_row   <= PIX_MAX;
      high_col  <= PIX_MIN;
      high_row  <= PIX_MIN;
      low_seen  <= 1'b0;
      high_seen <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        low_point[i]  <= '0;
        high_point[i] <= '0;
      end
    end else if (state == S_UPDATE) begin
      if (lo_hit) begin
        low_col  <= col_r;
        low_row  <= row_r;
        low_seen <= 1'b1;
        for (int i = 0; i < 3; i++) low_point[i] <= pt[i];
      end else if (hi_hit) begin
        high_col  <= col_r;
        high_row  <= row_r;
        high_seen <= 1'b1;
        for (int i = 0; i < 3; i++) high_point[i] <= pt[i];
      end
    end
  end

  // clamp a pixel value to 16 bits for the result
  function automatic logic signed [15:0] out16(logic signed [PB-1:0] v);
    logic signed [CW-1:0] e;
    e = CW'(v);
    if (e > OUT_MAX) e = OUT_MAX;
    if (e < OUT_MIN) e = OUT_MIN;
    return e[15:0];
  endfunction

  // result payload straight from the tracker registers
  always_comb begin
    if (state == S_EMIT_HI) begin
      corners.data.corner_kind  = 1'b1;
      corners.data.corner_found = high_seen;
      corners.data.corner_x     = high_point[0];
      corners.data.corner_y     = high_point[1];
      corners.data.corner_z     = high_point[2];
      corners.data.corner_col   = out16(high_col);
      corners.data.corner_row   = out16(high_row);
      corners.data.run_last     = 1'b1;
    end else begin
      corners.data.corner_kind  = 1'b0;
      corners.data.corner_found = low_seen;
      corners.data.corner_x     = low_point[0];
      corners.data.corner_y     = low_point[1];
      corners.data.corner_z     = low_point[2];
      corners.data.corner_col   = out16(low_col);
      corners.data.corner_row   = out16(low_row);
      corners.data.run_last     = 1'b0;
    end
  end

endmodule

// ----- rtl/core/pbct_checker.sv -----
// ----------------------------------------------------------------------------
// pbct_checker
// Port-level checks of the corner tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "projected_box_corner_tracker_macros.svh"

module pbct_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_kind,
  input logic out_last
);

  // a pending corner is held until transferred
  `PBCT_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // no point is taken while corners are going out
  `PBCT_ASSERT_IMP(a_busy_emit, clk, rst, out_valid, !in_ready)

  // the low corner is always followed by the high corner
  `PBCT_ASSERT_NXT(a_pair, clk, rst, out_valid && out_ready && !out_last,
                   out_valid && out_kind && out_last)

  // reset leaves the block empty and ready for points
  `PBCT_ASSERT_NXT_ALWAYS(a_reset, clk, rst, !out_valid && in_ready)

endmodule

bind projected_box_corner_tracker pbct_checker u_pbct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (points.ready),
  .out_valid (corners.valid),
  .out_ready (corners.ready),
  .out_kind  (corners.data.corner_kind),
  .out_last  (corners.data.run_last)
);
